// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the filter modules.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TDPF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define TDPF_ASSERT_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

`endif

// ----- sv/tdpf_pkg.sv -----
package tdpf_pkg;

   // Width of candidates and stored primes
   localparam int VALUE_W = 32;

   // Seed primes held in the table after reset
   localparam int SEED_COUNT = 4;
   localparam int SEED_IDX_W = 2;
   localparam logic [VALUE_W-1:0] SEED_PRIMES [SEED_COUNT] = '{
      32'd2, 32'd3, 32'd5, 32'd7
   };

   // Largest seed prime, the starting point of the rising sequence
   localparam logic [VALUE_W-1:0] RESET_LAST = 32'd7;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FETCH,
      ST_START,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // Status from the remainder unit
   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_status_type;

endpackage

// ----- sv/tdpf_rem_unit.sv -----
`include "assert_macros.svh"

module tdpf_rem_unit
   import tdpf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] dividend,
   input  logic [VALUE_W-1:0] divisor,
   output div_status_type     status
);

   localparam int STEP_W = $clog2(VALUE_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [VALUE_W-1:0] dvd_ff, dvd_in;
   logic [VALUE_W-1:0] dsr_ff, dsr_in;
   logic [VALUE_W:0]   shifted;
   logic [VALUE_W:0]   diff;

   // Restoring step: bring in one dividend bit, subtract when it fits
   always_comb begin
      shifted = {rem_ff, dvd_ff[VALUE_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[VALUE_W-2:0], 1'b0};
         rem_in  = diff[VALUE_W] ? shifted[VALUE_W-1:0] : diff[VALUE_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

   `TDPF_ASSERT_IMPLY(a_start_idle, start, !busy_ff, "remainder unit restarted while busy")
   `TDPF_ASSERT(a_done_after_busy, done_ff |-> $past(busy_ff), "done without a running division")
   `TDPF_ASSERT_IMPLY(a_done_not_busy, done_ff, !busy_ff, "done while still dividing")

endmodule

// ----- sv/tdpf_table.sv -----
module tdpf_table
   import tdpf_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  logic [VALUE_W-1:0]             wr_data,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output logic [VALUE_W-1:0]             rd_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W:0] SEED_END = (IDX_W + 1)'(SEED_COUNT);

   logic [VALUE_W-1:0] mem [TABLE_DEPTH];
   logic [VALUE_W-1:0] mem_q_ff;
   logic [VALUE_W-1:0] seed_q_ff;
   logic               seed_sel_ff;

   // Write appended primes
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read registered; low entries come from the seed constants
   always_ff @(posedge clock) begin
      mem_q_ff    <= mem[rd_addr];
      seed_q_ff   <= SEED_PRIMES[rd_addr[SEED_IDX_W-1:0]];
      seed_sel_ff <= ({1'b0, rd_addr} < SEED_END);
   end

   assign rd_data = seed_sel_ff ? seed_q_ff : mem_q_ff;

endmodule

// ----- sv/trial_division_prime_filter_top.sv -----
// Trial-division prime filter. Candidates must arrive in rising order; one
// that is not above the last accepted candidate comes back with rejected set
// and leaves the state alone. Each accepted candidate is divided by every
// stored prime in turn (table seeded with 2, 3, 5, 7) and the walk stops at the
// first exact divisor. A prime is appended to the table; once TABLE_DEPTH
// primes are held it is reported with not_stored set. One shared bit-serial
// remainder unit does all division, trying one stored prime at a time. Only
// one item is in work at a time; a finished item waits in the output register
// while the next one is taken in. The block needs no clearing pass after reset.
`include "assert_macros.svh"

module trial_division_prime_filter_top
   import tdpf_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_candidate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_tested_value,
   output logic        rsp_is_prime,
   output logic        rsp_not_stored,
   output logic        rsp_rejected
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] SEED_CNT  = CNT_W'(SEED_COUNT);

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] cand_ff;
   logic [VALUE_W-1:0] last_ff;
   logic [CNT_W-1:0]   held_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   idx_next;
   logic               res_prime_ff;
   logic               res_full_ff;
   logic               res_rej_ff;
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_prime_ff;
   logic               rsp_full_ff;
   logic               rsp_rej_ff;

   logic               accept;
   logic               reject;
   logic               last_prime;
   logic               table_full;
   logic               div_start;
   logic               found_prime;
   logic               wr_en;
   logic               out_load;
   logic [VALUE_W-1:0] divisor;
   div_status_type     div_stat;

   assign idx_next   = idx_ff + 1'b1;
   assign reject     = (cand_ff <= last_ff);
   assign last_prime = (idx_next == held_ff);
   assign table_full = (held_ff == DEPTH_CNT);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = reject ? ST_DONE : ST_FETCH;
         end
         ST_FETCH: state_in = ST_START;
         ST_START: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_stat.done) begin
               if (div_stat.rem_zero || last_prime) state_in = ST_DONE;
               else state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Decode actions of the current state
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      accept      = (state_ff == ST_IDLE) && req_valid;
      div_start   = (state_ff == ST_START);
      found_prime = (state_ff == ST_DIVIDE) && div_stat.done && !div_stat.rem_zero
                    && last_prime;
      wr_en       = found_prime && !table_full;
      out_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the item and walk the table
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= RESET_LAST;
         held_ff <= SEED_CNT;
      end else begin
         if (state_ff == ST_CHECK && !reject) last_ff <= cand_ff;
         if (wr_en) held_ff <= held_ff + 1'b1;
      end
      if (accept) cand_ff <= req_candidate;
      if (state_ff == ST_CHECK) begin
         idx_ff       <= '0;
         res_rej_ff   <= reject;
         res_prime_ff <= 1'b0;
         res_full_ff  <= 1'b0;
      end
      // Advance to the next stored prime only while one is left
      if (state_ff == ST_DIVIDE && div_stat.done && !div_stat.rem_zero && !last_prime) begin
         idx_ff <= idx_next;
      end
      if (found_prime) begin
         res_prime_ff <= 1'b1;
         res_full_ff  <= table_full;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_value_ff <= cand_ff;
         rsp_prime_ff <= res_prime_ff;
         rsp_full_ff  <= res_full_ff;
         rsp_rej_ff   <= res_rej_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tested_value = rsp_value_ff;
   assign rsp_is_prime     = rsp_prime_ff;
   assign rsp_not_stored   = rsp_full_ff;
   assign rsp_rejected     = rsp_rej_ff;

   tdpf_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (held_ff[IDX_W-1:0]),
      .wr_data (cand_ff),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (divisor)
   );

   tdpf_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cand_ff),
      .divisor  (divisor),
      .status   (div_stat)
   );

   `TDPF_ASSERT_IMPLY(a_write_room, wr_en, held_ff < DEPTH_CNT, "append into a full table")
   `TDPF_ASSERT_IMPLY(a_done_in_divide, div_stat.done, state_ff == ST_DIVIDE, "stray result")
   `TDPF_ASSERT_IMPLY(a_flags_excl, rsp_valid && rsp_rejected, !rsp_is_prime && !rsp_not_stored, "bad flags")
   `TDPF_ASSERT_IMPLY(a_full_is_prime, rsp_valid && rsp_not_stored, rsp_is_prime, "not_stored without prime")
   `TDPF_ASSERT_IMPLY(a_walk_bound, state_ff != ST_IDLE, idx_ff < held_ff || state_ff == ST_CHECK, "walk overrun")

endmodule

// ----- dv/tb_trial_division_prime_filter_top.sv -----
`timescale 1ns / 100ps

module tb_trial_division_prime_filter_top;
   import tdpf_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 8;
   // Small table so that it fills early and every item stays short
   localparam int TABLE_SIZE     = 16;
   localparam int DIRECTED_ROWS  = 25;
   localparam int TAIL_ROWS      = 3;
   localparam int RANDOM_ITEMS   = 72;
   localparam int QUIET_ITEMS    = 20;
   localparam int HOLD_AT_ITEM   = 40;
   localparam int LONG_HOLD      = 700;
   // Time for the worst item, with every stored prime tried
   localparam int DRAIN_CYCLES   = 3 + 35 * TABLE_SIZE + 40;
   localparam int WATCHDOG_LIMIT = 8 * (LONG_HOLD + DRAIN_CYCLES);
   localparam int MAX_REPORTS    = 10;
   localparam logic [63:0] VALUE_CAP = 64'hFFFF_FFFE;

   typedef struct packed {
      logic [VALUE_W-1:0] tested_value;
      logic               is_prime;
      logic               not_stored;
      logic               rejected;
   } filter_result_type;

   typedef struct packed {
      logic [VALUE_W-1:0] cand;
      logic               typed;
      filter_result_type  want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [VALUE_W-1:0] req_candidate = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [VALUE_W-1:0] rsp_tested_value;
   logic               rsp_is_prime;
   logic               rsp_not_stored;
   logic               rsp_rejected;

   // Predictor state: own copy of the prime table
   logic [VALUE_W-1:0] prime_store [TABLE_SIZE];
   int unsigned        primes_kept;
   logic [VALUE_W-1:0] last_taken;

   filter_result_type  expected_results [$];
   stim_row_type       directed_rows [DIRECTED_ROWS];
   stim_row_type       tail_rows [TAIL_ROWS];

   logic               quiet = 1'b0;
   logic               hold_off_req = 1'b0;
   int                 mismatches = 0;
   int                 items_sent = 0;
   int                 primes_seen = 0;
   int                 unstored_seen = 0;
   int                 rejects_seen = 0;
   int                 holds_done = 0;
   int                 idle_cycles = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   trial_division_prime_filter_top #(
      .TABLE_DEPTH (TABLE_SIZE)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_candidate    (req_candidate),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tested_value (rsp_tested_value),
      .rsp_is_prime     (rsp_is_prime),
      .rsp_not_stored   (rsp_not_stored),
      .rsp_rejected     (rsp_rejected)
   );

   // Seed the predictor table as the block does at reset
   function automatic void seed_primes();
      for (int i = 0; i < TABLE_SIZE; i++) prime_store[i] = '0;
      for (int i = 0; i < SEED_COUNT; i++) prime_store[i] = SEED_PRIMES[i];
      primes_kept = SEED_COUNT;
      last_taken  = RESET_LAST;
   endfunction

   // Trial-divide one candidate and advance the predictor state
   function automatic filter_result_type test_candidate(input logic [VALUE_W-1:0] cand);
      filter_result_type res;
      logic              divided;
      res = '{tested_value: cand, is_prime: 1'b0, not_stored: 1'b0, rejected: 1'b0};
      divided = 1'b0;
      if (cand <= last_taken) begin
         res.rejected = 1'b1;
      end else begin
         last_taken = cand;
         for (int unsigned i = 0; i < primes_kept; i++) begin
            if (prime_store[i] != '0 && (cand % prime_store[i]) == '0) divided = 1'b1;
         end
         if (!divided) begin
            res.is_prime = 1'b1;
            if (primes_kept < TABLE_SIZE) begin
               prime_store[primes_kept] = cand;
               primes_kept++;
            end else begin
               res.not_stored = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic stim_row_type typed_row(input logic [VALUE_W-1:0] cand,
                                              input logic prime, input logic unstored,
                                              input logic rej);
      stim_row_type row;
      row.cand  = cand;
      row.typed = 1'b1;
      row.want  = '{tested_value: cand, is_prime: prime, not_stored: unstored, rejected: rej};
      return row;
   endfunction

   function automatic stim_row_type open_row(input logic [VALUE_W-1:0] cand);
      stim_row_type row;
      row       = '0;
      row.cand  = cand;
      return row;
   endfunction

   // Offer one item, hold it until accepted, then queue its expected result
   task automatic send_item(input stim_row_type row);
      filter_result_type predicted;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_candidate <= row.cand;
      do @(posedge clock); while (req_stall);
      predicted = test_candidate(row.cand);
      if (row.typed) predicted = row.want;
      expected_results.push_back(predicted);
      items_sent++;
      if (predicted.rejected) rejects_seen++;
      if (predicted.is_prime) primes_seen++;
      if (predicted.not_stored) unstored_seen++;
      @(negedge clock);
   endtask

   function automatic void report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
   endfunction

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      filter_result_type got;
      filter_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{tested_value: rsp_tested_value, is_prime: rsp_is_prime,
                 not_stored: rsp_not_stored, rejected: rsp_rejected};
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf(
               "result with nothing expected: value %h prime %b %s %b rej %b",
               got.tested_value, got.is_prime, "unstored", got.not_stored,
               got.rejected));
         end else begin
            want = expected_results.pop_front();
            if (got !== want)
               report_mismatch($sformatf(
                  "expected value %h prime %b unstored %b rej %b, got %h %b %b %b",
                  want.tested_value, want.is_prime, want.not_stored, want.rejected,
                  got.tested_value, got.is_prime, got.not_stored, got.rejected));
         end
      end
   end

   // Abort when no item moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, one long hold on request
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 16)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, quiet ? 0 : 16)) @(negedge clock);
         end
      end
   end

   // Sender: directed table, random rising sequence, closing extremes
   initial begin
      logic [63:0] next_val;
      logic [63:0] step_prime;
      int          pick;
      seed_primes();
      directed_rows = '{
         typed_row(32'd0, 1'b0, 1'b0, 1'b1),
         typed_row(32'd7, 1'b0, 1'b0, 1'b1),
         typed_row(32'd5, 1'b0, 1'b0, 1'b1),
         typed_row(32'd8, 1'b0, 1'b0, 1'b0),
         open_row(32'd9),
         typed_row(32'd11, 1'b1, 1'b0, 1'b0),
         typed_row(32'd11, 1'b0, 1'b0, 1'b1),
         typed_row(32'd10, 1'b0, 1'b0, 1'b1),
         open_row(32'd13),
         open_row(32'd121),
         open_row(32'd17),
         open_row(32'd19),
         open_row(32'd23),
         open_row(32'd29),
         open_row(32'd31),
         open_row(32'd37),
         open_row(32'd41),
         open_row(32'd43),
         open_row(32'd47),
         open_row(32'd53),
         open_row(32'd59),
         open_row(32'd2809),
         open_row(32'd3481),
         open_row(32'd3599),
         open_row(32'd3600)
      };
      tail_rows = '{
         open_row(32'hFFFF_FFFF),
         typed_row(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1),
         typed_row(32'd0, 1'b0, 1'b0, 1'b1)
      };

      // Hold reset, then release on a falling edge
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);

      // Mostly rising candidates with random steps, some stale ones mixed in
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
         if (n == HOLD_AT_ITEM) hold_off_req = 1'b1;
         pick = $urandom_range(0, 99);
         if (n == RANDOM_ITEMS / 2) begin
            // Climb to just under the top bit so later steps cross it
            next_val = 64'h7FFF_FFC0 + $urandom_range(0, 15);
         end else if (pick < 45) begin
            next_val = last_taken + $urandom_range(1, 64);
         end else if (pick < 70) begin
            step_prime = prime_store[$urandom_range(0, primes_kept - 1)];
            next_val = step_prime * (last_taken / step_prime + 1);
         end else if (pick < 90) begin
            next_val = last_taken + $urandom_range(1, 4096);
         end else begin
            next_val = last_taken + $urandom_range(1, 1 << 20);
         end
         if (pick >= 85 && n != RANDOM_ITEMS / 2) begin
            // Stale item: repeat, zero, or anything not above the last one
            case ($urandom_range(0, 2))
               0:       next_val = last_taken;
               1:       next_val = 64'd0;
               default: next_val = $urandom_range(0, last_taken);
            endcase
         end
         if (next_val > VALUE_CAP) next_val = last_taken;
         send_item(open_row(next_val[VALUE_W-1:0]));
      end

      foreach (tail_rows[i]) send_item(tail_rows[i]);
      req_valid <= 1'b0;

      // Drain, then give stray results time to show up
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d candidates: %0d prime (%0d past a full table), %0d rejected.",
               items_sent, primes_seen, unstored_seen, rejects_seen);
      $display("Prime table of %0d entries, %0d long output holds, %0d mismatches.",
               TABLE_SIZE, holds_done, mismatches);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
